[sv/edpt_pkg.sv]
// Shared types, codes and tables of the encoder door position tracker.
package edpt_pkg;

    localparam logic [2:0] FN_SAMPLE = 3'd0;
    localparam logic [2:0] FN_TICK   = 3'd1;
    localparam logic [2:0] FN_OPEN   = 3'd2;
    localparam logic [2:0] FN_CLOSE  = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;
    localparam logic [2:0] FN_PRIME  = 3'd5;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] INT_NONE  = 2'd0;
    localparam logic [1:0] INT_OPEN  = 2'd1;
    localparam logic [1:0] INT_CLOSE = 2'd2;

    localparam logic [2:0] ST_OPEN    = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_OPENING = 3'd2;
    localparam logic [2:0] ST_CLOSING = 3'd3;
    localparam logic [2:0] ST_STOPPED = 3'd4;

    localparam logic [1:0] RETRY_NONE  = 2'd0;
    localparam logic [1:0] RETRY_OPEN  = 2'd1;
    localparam logic [1:0] RETRY_CLOSE = 2'd2;

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    localparam logic [2:0] CFG_REVERSED  = 3'd0;
    localparam logic [2:0] CFG_DRAIN     = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd2;
    localparam logic [2:0] CFG_REV_THR   = 3'd3;
    localparam logic [2:0] CFG_STOP_DLY  = 3'd4;
    localparam logic [2:0] CFG_SUB_STEPS = 3'd5;

    localparam logic [9:0]  DRAIN_RST     = 10'd100;
    localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
    localparam logic [3:0]  REV_THR_RST   = 4'd3;
    localparam logic [15:0] STOP_DLY_RST  = 16'd500;
    localparam logic [3:0]  SUB_STEPS_RST = 4'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] func;
        logic       pin_a;
        logic       pin_b;
    } t_req;

    typedef struct packed {
        logic               report_valid;
        logic [2:0]         door_status;
        logic               position_known;
        logic [6:0]         position_pct;
        logic signed [15:0] step_count;
        logic               stop_request;
        logic [1:0]         retry_command;
        logic               save_request;
        logic signed [15:0] low_limit;
        logic signed [15:0] high_limit;
    } t_res;

    typedef struct packed {
        logic        reversed;
        logic [9:0]  drain_period_ms;
        logic [15:0] stopped_timeout_ms;
        logic [3:0]  reversal_threshold;
        logic [15:0] stop_delay_ms;
        logic [3:0]  subcounts_per_step;
    } t_cfg;

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] step;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE, BS_UPD, BS_PCT, BS_DIV, BS_MOT, BS_WD, BS_STOP, BS_DONE
    } t_bstate;

    // Quadrature transition table, index {previous A, previous B, A, B}.
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

[sv/edpt_front.sv]
// Front end: decodes quadrature samples into whole steps and classifies each request.
module edpt_front import edpt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_req       i_req,
    input  logic [3:0] i_sub_steps,
    output t_cmd       o_cmd
);

    logic [1:0]        r_prev_pins, n_prev_pins;
    logic signed [4:0] r_acc, n_acc;
    logic [1:0]        pins;
    logic signed [1:0] s;
    logic signed [4:0] acc_sum;
    logic signed [4:0] thr;
    logic              ge, le;

    assign pins    = {i_req.pin_a, i_req.pin_b};
    assign s       = quad_step({r_prev_pins, pins});
    assign acc_sum = r_acc + 5'(s);
    assign thr     = $signed({1'b0, i_sub_steps});
    assign ge      = acc_sum >= thr;
    assign le      = acc_sum <= -thr;

    always_comb begin
        o_cmd.func = i_req.func;
        o_cmd.step = STEP_NONE;
        if (i_req.func == FN_SAMPLE && s != 2'sd0) begin
            if (ge) begin
                o_cmd.step = STEP_UP;
            end else if (le) begin
                o_cmd.step = STEP_DOWN;
            end
        end
    end

    always_comb begin
        n_prev_pins = r_prev_pins;
        n_acc       = r_acc;
        if (i_accept) begin
            case (i_req.func)
                FN_SAMPLE: begin
                    n_prev_pins = pins;
                    if (s != 2'sd0) begin
                        n_acc = (ge || le) ? 5'sd0 : acc_sum;
                    end
                end
                FN_CLEAR: n_acc = 5'sd0;
                FN_PRIME: n_prev_pins = pins;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= 2'b00;
            r_acc       <= 5'sd0;
        end else begin
            r_prev_pins <= n_prev_pins;
            r_acc       <= n_acc;
        end
    end

endmodule

[sv/edpt_queue.sv]
// Short command queue between the front end and the back end.
module edpt_queue import edpt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_rd, n_rd, r_wr, n_wr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_rd  = r_rd;
        n_wr  = r_wr;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

endmodule

[sv/edpt_back.sv]
// Back end: sequencer for drains, position, direction, watchdog and calibration.
module edpt_back import edpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_out_ready,
    output logic o_res_load,
    output t_res o_res
);

    t_bstate r_state, n_state;

    logic [15:0] r_pend, n_pend, r_applied, n_applied, r_lo, n_lo, r_hi, n_hi;
    logic        r_lo_ok, n_lo_ok, r_hi_ok, n_hi_ok;
    logic [1:0]  r_travel, n_travel, r_last, n_last;
    logic [3:0]  r_revcnt, n_revcnt;
    logic [1:0]  r_intent, n_intent, r_corr_dir, n_corr_dir;
    logic        r_corr_pend, n_corr_pend, r_armed, n_armed;
    logic [15:0] r_ms_step, n_ms_step, r_ms_drain, n_ms_drain, r_cd, n_cd;
    logic [6:0]  r_pos, n_pos;
    logic        r_pos_ok, n_pos_ok;

    logic        r_rep_valid, n_rep_valid, r_stop_fire, n_stop_fire;
    logic        r_save_fire, n_save_fire;
    logic [2:0]  r_rep_state, n_rep_state;
    logic [1:0]  r_retry, n_retry;

    logic [15:0]        r_raw, n_raw;
    logic [16:0]        r_dc, n_dc, r_dop, n_dop;
    logic signed [17:0] r_n, n_n;
    logic [16:0]        r_d, n_d;
    logic [23:0]        r_num, n_num;
    logic [16:0]        r_div, n_div;
    logic [6:0]         r_quo, n_quo;
    logic [2:0]         r_bit, n_bit;
    logic               r_dec, n_dec, r_beyond, n_beyond;

    // Shared conditions
    logic [15:0]        ms_step_inc, ms_drain_inc, delta;
    logic               drain_go, delta_nz, both_ok, cal_ok, wd_go;
    logic signed [16:0] rs, los, his, diff_lo, diff_hi, span;
    logic signed [17:0] n_abs;
    logic [16:0]        span_abs, n17;
    logic [23:0]        trial;
    logic               div_ge;
    logic [1:0]         eff;
    logic [2:0]         motion;
    logic signed [16:0] cur, tc, to_end;
    logic               ac, ao;

    assign ms_step_inc  = (r_ms_step == 16'hFFFF) ? r_ms_step : r_ms_step + 16'd1;
    assign ms_drain_inc = (r_ms_drain == 16'hFFFF) ? r_ms_drain : r_ms_drain + 16'd1;
    assign drain_go     = ms_drain_inc >= {6'd0, i_cfg.drain_period_ms};
    assign delta        = r_raw - r_applied;
    assign delta_nz     = delta != 16'd0;
    assign both_ok      = r_lo_ok && r_hi_ok;
    assign cal_ok       = both_ok && (r_lo != r_hi);
    assign wd_go        = r_armed && (r_ms_step >= i_cfg.stopped_timeout_ms);

    assign rs       = $signed({r_raw[15], r_raw});
    assign los      = $signed({r_lo[15], r_lo});
    assign his      = $signed({r_hi[15], r_hi});
    assign diff_lo  = rs - los;
    assign diff_hi  = rs - his;
    assign span     = his - los;
    assign span_abs = span[16] ? 17'(-span) : 17'(span);
    assign n_abs    = span[16] ? -18'(diff_lo) : 18'(diff_lo);

    assign n17    = r_n[16:0];
    assign trial  = {7'd0, r_div} << r_bit;
    assign div_ge = r_num >= trial;

    assign eff    = (r_travel != DIR_IDLE) ? r_travel : r_last;
    assign motion = (eff == DIR_UP) ? (i_cfg.reversed ? ST_CLOSING : ST_OPENING)
                                    : (i_cfg.reversed ? ST_OPENING : ST_CLOSING);

    assign cur    = $signed({r_applied[15], r_applied});
    assign tc     = i_cfg.reversed ? his : los;
    assign to_end = i_cfg.reversed ? los : his;
    assign ac     = r_dec == !i_cfg.reversed;
    assign ao     = r_dec == i_cfg.reversed;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.func == FN_TICK) begin
                        n_state = (drain_go && r_pend != 16'd0) ? BS_UPD : BS_WD;
                    end else begin
                        n_state = BS_DONE;
                    end
                end
            end
            BS_UPD: begin
                if (!delta_nz) begin
                    n_state = BS_WD;
                end else if (cal_ok) begin
                    n_state = BS_PCT;
                end else begin
                    n_state = BS_MOT;
                end
            end
            BS_PCT: begin
                if ((r_dc <= 17'd1 && r_dc <= r_dop) || (r_dop <= 17'd1 && r_dop < r_dc)
                    || r_n <= 18'sd0 || r_n >= $signed({1'b0, r_d})) begin
                    n_state = BS_MOT;
                end else begin
                    n_state = BS_DIV;
                end
            end
            BS_DIV: n_state = (r_bit == 3'd0) ? BS_MOT : BS_DIV;
            BS_MOT: n_state = BS_WD;
            BS_WD: begin
                if (wd_go && !r_corr_pend && both_ok) begin
                    n_state = BS_STOP;
                end else begin
                    n_state = BS_DONE;
                end
            end
            BS_STOP: n_state = BS_DONE;
            BS_DONE: n_state = i_out_ready ? BS_IDLE : BS_DONE;
            default: n_state = BS_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_cmd_pop  = (r_state == BS_IDLE) && i_cmd_valid;
        o_res_load = (r_state == BS_DONE) && i_out_ready;
    end

    always_comb begin
        o_res.report_valid   = r_rep_valid;
        o_res.door_status    = r_rep_state;
        o_res.position_known = r_pos_ok;
        o_res.position_pct   = r_pos_ok ? r_pos : 7'd0;
        o_res.step_count     = $signed(r_applied);
        o_res.stop_request   = r_stop_fire;
        o_res.retry_command  = r_retry;
        o_res.save_request   = r_save_fire;
        o_res.low_limit      = $signed(r_lo);
        o_res.high_limit     = $signed(r_hi);
    end

    // Datapath
    always_comb begin
        n_pend = r_pend; n_applied = r_applied; n_lo = r_lo; n_hi = r_hi;
        n_lo_ok = r_lo_ok; n_hi_ok = r_hi_ok; n_travel = r_travel; n_last = r_last;
        n_revcnt = r_revcnt; n_intent = r_intent; n_corr_dir = r_corr_dir;
        n_corr_pend = r_corr_pend; n_armed = r_armed; n_ms_step = r_ms_step;
        n_ms_drain = r_ms_drain; n_cd = r_cd; n_pos = r_pos; n_pos_ok = r_pos_ok;
        n_rep_valid = r_rep_valid; n_rep_state = r_rep_state;
        n_stop_fire = r_stop_fire; n_save_fire = r_save_fire; n_retry = r_retry;
        n_raw = r_raw; n_dc = r_dc; n_dop = r_dop; n_n = r_n; n_d = r_d;
        n_num = r_num; n_div = r_div; n_quo = r_quo; n_bit = r_bit;
        n_dec = r_dec; n_beyond = r_beyond;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_rep_valid = 1'b0;
                    n_rep_state = ST_OPEN;
                    n_stop_fire = 1'b0;
                    n_save_fire = 1'b0;
                    n_retry     = RETRY_NONE;
                    case (i_cmd.func)
                        FN_SAMPLE: begin
                            if (i_cmd.step == STEP_UP) begin
                                n_pend = r_pend + 16'd1;
                            end else if (i_cmd.step == STEP_DOWN) begin
                                n_pend = r_pend - 16'd1;
                            end
                        end
                        FN_TICK: begin
                            if (r_cd != 16'd0) begin
                                n_cd = r_cd - 16'd1;
                                if (r_cd == 16'd1) begin
                                    n_stop_fire = 1'b1;
                                end
                            end
                            n_ms_step  = ms_step_inc;
                            n_ms_drain = ms_drain_inc;
                            if (drain_go) begin
                                n_ms_drain = 16'd0;
                                n_pend     = 16'd0;
                                n_raw      = r_applied + r_pend;
                            end
                        end
                        FN_OPEN:  n_intent = INT_OPEN;
                        FN_CLOSE: n_intent = INT_CLOSE;
                        FN_CLEAR: begin
                            n_pend = 16'd0; n_applied = 16'd0; n_lo = 16'd0; n_hi = 16'd0;
                            n_lo_ok = 1'b0; n_hi_ok = 1'b0; n_travel = DIR_IDLE;
                            n_revcnt = 4'd0; n_intent = INT_NONE; n_corr_pend = 1'b0;
                            n_armed = 1'b0; n_save_fire = 1'b1;
                        end
                        FN_PRIME: n_pend = 16'd0;
                        default: ;
                    endcase
                end
            end
            BS_UPD: begin
                n_applied = r_raw;
                if (delta_nz) begin
                    n_last = delta[15] ? DIR_DOWN : DIR_UP;
                    if (r_travel == DIR_IDLE) begin
                        n_travel = n_last;
                        n_revcnt = 4'd0;
                    end else if (n_last != r_travel) begin
                        n_revcnt = r_revcnt + 4'd1;
                        if (n_revcnt >= i_cfg.reversal_threshold) begin
                            n_travel = n_last;
                            n_revcnt = 4'd0;
                        end
                    end else begin
                        n_revcnt = 4'd0;
                    end
                end
                n_dc  = diff_lo[16] ? 17'(-diff_lo) : 17'(diff_lo);
                n_dop = diff_hi[16] ? 17'(-diff_hi) : 17'(diff_hi);
                n_d   = span_abs;
                n_n   = i_cfg.reversed ? $signed({1'b0, span_abs}) - n_abs : n_abs;
            end
            BS_PCT: begin
                n_pos_ok = 1'b1;
                n_quo    = 7'd0;
                n_bit    = 3'd6;
                n_num    = ({7'd0, n17} << 7) + ({7'd0, n17} << 6) + ({7'd0, n17} << 3)
                           + {7'd0, r_d};
                n_div    = {r_d[15:0], 1'b0};
                if (r_dc <= 17'd1 && r_dc <= r_dop) begin
                    n_pos = i_cfg.reversed ? 7'd100 : 7'd0;
                end else if (r_dop <= 17'd1 && r_dop < r_dc) begin
                    n_pos = i_cfg.reversed ? 7'd0 : 7'd100;
                end else if (r_n <= 18'sd0) begin
                    n_pos = 7'd0;
                end else if (r_n >= $signed({1'b0, r_d})) begin
                    n_pos = 7'd100;
                end
            end
            BS_DIV: begin
                // One quotient bit a cycle, most significant first
                if (div_ge) begin
                    n_num = r_num - trial;
                end
                n_quo = {r_quo[5:0], div_ge};
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    n_pos = n_quo;
                end
            end
            BS_MOT: begin
                if (cal_ok) begin
                    if (r_intent != INT_NONE
                        && ((motion == ST_OPENING) != (r_intent == INT_OPEN))) begin
                        n_corr_pend = 1'b1;
                        n_corr_dir  = r_intent;
                        n_intent    = INT_NONE;
                        n_cd        = i_cfg.stop_delay_ms;
                        if (i_cfg.stop_delay_ms == 16'd0) begin
                            n_stop_fire = 1'b1;
                        end
                    end else begin
                        n_rep_valid = 1'b1;
                        n_rep_state = motion;
                    end
                end
                n_ms_step = 16'd0;
                n_armed   = 1'b1;
            end
            BS_WD: begin
                if (wd_go) begin
                    n_armed = 1'b0;
                    if (r_corr_pend) begin
                        n_corr_pend = 1'b0;
                        if (r_corr_dir == INT_OPEN) begin
                            n_retry = RETRY_OPEN;
                        end else if (r_corr_dir == INT_CLOSE) begin
                            n_retry = RETRY_CLOSE;
                        end
                        n_corr_dir = INT_NONE;
                    end else begin
                        n_dec    = r_travel == DIR_DOWN;
                        n_travel = DIR_IDLE;
                        n_revcnt = 4'd0;
                        n_intent = INT_NONE;
                        if (!both_ok) begin
                            // Learn the end we just reached
                            n_save_fire = 1'b1;
                            n_rep_valid = 1'b1;
                            n_pos_ok    = 1'b1;
                            if (n_dec) begin
                                n_lo = r_applied;
                                n_lo_ok = 1'b1;
                            end else begin
                                n_hi = r_applied;
                                n_hi_ok = 1'b1;
                            end
                            if (n_dec != i_cfg.reversed) begin
                                n_rep_state = ST_CLOSED;
                                n_pos = 7'd0;
                            end else begin
                                n_rep_state = ST_OPEN;
                                n_pos = 7'd100;
                            end
                        end else begin
                            n_dc     = (cur - tc) < 0 ? 17'(tc - cur) : 17'(cur - tc);
                            n_dop    = (cur - to_end) < 0 ? 17'(to_end - cur)
                                                          : 17'(cur - to_end);
                            n_beyond = n_dec ? (cur < los) : (cur > his);
                        end
                    end
                end
            end
            BS_STOP: begin
                // Snap or extend a limit, or report a mid-travel stop
                n_rep_valid = 1'b1;
                n_rep_state = ST_STOPPED;
                if ((r_dc <= 17'd1 && r_dc <= r_dop && ac) || (ac && r_beyond
                    && !(r_dop <= 17'd1 && r_dop < r_dc && ao) && !ao)) begin
                    n_rep_state = ST_CLOSED;
                end else if ((r_dop <= 17'd1 && r_dop < r_dc && ao) || (ao && r_beyond)) begin
                    n_rep_state = ST_OPEN;
                end else if (ac && r_beyond) begin
                    n_rep_state = ST_CLOSED;
                end
                if (n_rep_state != ST_STOPPED) begin
                    n_save_fire = 1'b1;
                    n_pos_ok    = 1'b1;
                    n_pos       = (n_rep_state == ST_OPEN) ? 7'd100 : 7'd0;
                    if (r_dec) begin
                        n_lo = r_applied;
                    end else begin
                        n_hi = r_applied;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_raw <= n_raw; r_dc <= n_dc; r_dop <= n_dop; r_n <= n_n; r_d <= n_d;
        r_num <= n_num; r_div <= n_div; r_quo <= n_quo; r_bit <= n_bit;
        r_dec <= n_dec; r_beyond <= n_beyond; r_rep_state <= n_rep_state;
        r_retry <= n_retry;
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_pend <= 16'd0; r_applied <= 16'd0; r_lo <= 16'd0; r_hi <= 16'd0;
            r_lo_ok <= 1'b0; r_hi_ok <= 1'b0; r_travel <= DIR_IDLE; r_last <= DIR_IDLE;
            r_revcnt <= 4'd0; r_intent <= INT_NONE; r_corr_dir <= INT_NONE;
            r_corr_pend <= 1'b0; r_armed <= 1'b0; r_ms_step <= 16'd0;
            r_ms_drain <= 16'd0; r_cd <= 16'd0; r_pos <= 7'd0; r_pos_ok <= 1'b0;
            r_rep_valid <= 1'b0; r_stop_fire <= 1'b0; r_save_fire <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend <= n_pend; r_applied <= n_applied; r_lo <= n_lo; r_hi <= n_hi;
            r_lo_ok <= n_lo_ok; r_hi_ok <= n_hi_ok; r_travel <= n_travel; r_last <= n_last;
            r_revcnt <= n_revcnt; r_intent <= n_intent; r_corr_dir <= n_corr_dir;
            r_corr_pend <= n_corr_pend; r_armed <= n_armed; r_ms_step <= n_ms_step;
            r_ms_drain <= n_ms_drain; r_cd <= n_cd; r_pos <= n_pos; r_pos_ok <= n_pos_ok;
            r_rep_valid <= n_rep_valid; r_stop_fire <= n_stop_fire;
            r_save_fire <= n_save_fire;
        end
    end

endmodule

[sv/encoder_door_position_tracker.sv]
// Top level: encoder door position tracker with queue-style request and result ports.
// Requests are taken while the command queue has room; the back-end sequencer handles one
//   command at a time and waits while the result register is full. Its divider for the
//   position percent makes one bit a cycle (7 steps).
// Reset (i_rst_n low at a clock edge) empties the queues, loads the register defaults
//   and clears all tracking state; no clearing pass is needed.
module encoder_door_position_tracker import edpt_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_req        i_req,
    output logic        empty,
    input  logic        pop,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    t_res back_res, r_out;
    logic q_full, q_valid, q_pop, accept;
    logic r_out_valid, out_ready, res_load;

    // A request is taken whenever the command queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    // Configuration registers; writes must arrive only while the block is idle (the block itself does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reversed           <= 1'b0;
            r_cfg.drain_period_ms    <= DRAIN_RST;
            r_cfg.stopped_timeout_ms <= TIMEOUT_RST;
            r_cfg.reversal_threshold <= REV_THR_RST;
            r_cfg.stop_delay_ms      <= STOP_DLY_RST;
            r_cfg.subcounts_per_step <= SUB_STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REVERSED:  r_cfg.reversed           <= i_cfg_data[0];
                CFG_DRAIN:     r_cfg.drain_period_ms    <= i_cfg_data[9:0];
                CFG_TIMEOUT:   r_cfg.stopped_timeout_ms <= i_cfg_data;
                CFG_REV_THR:   r_cfg.reversal_threshold <= i_cfg_data[3:0];
                CFG_STOP_DLY:  r_cfg.stop_delay_ms      <= i_cfg_data;
                CFG_SUB_STEPS: r_cfg.subcounts_per_step <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Front end: decode encoder transitions, classify the request
    edpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_sub_steps (r_cfg.subcounts_per_step),
        .o_cmd       (front_cmd)
    );

    // Decouple the front end from the multi-cycle back end
    edpt_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // Back end: drain, position, direction, stop handling and calibration
    edpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_out_ready (out_ready),
        .o_res_load  (res_load),
        .o_res       (back_res)
    );

    // Result register: hold the oldest result until popped, refill in the same cycle
    assign out_ready = !r_out_valid || pop;
    assign empty     = !r_out_valid;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= back_res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

[sim/tb_encoder_door_position_tracker.sv]
// Self-checking testbench of the encoder door position tracker: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_encoder_door_position_tracker;
    import edpt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_req        i_req;
    logic        empty;
    logic        pop;
    t_res        o_res;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    encoder_door_position_tracker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Directed row: request plus an optional hand-written expectation.
    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_dir_row;

    // Quadrature transition deltas, index {previous A, previous B, A, B}.
    const int quad_lut[16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
    // Gray order of the channel levels for one full electrical cycle.
    const logic [1:0] gray_seq[4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    // Mirror of the tracker registers.
    int c_rev, c_drain, c_timeout, c_thr, c_delay, c_sub;

    // Mirror of the tracker state.
    logic [1:0]  m_pins;
    int          m_sub;
    logic [15:0] m_pend, m_applied, m_lo, m_hi;
    bit          m_lo_ok, m_hi_ok;
    logic [1:0]  m_travel, m_last, m_intent, m_corr_dir;
    logic [3:0]  m_revcnt;
    bit          m_corr, m_wd;
    int          m_ms_step, m_ms_drain, m_countdown, m_pos;
    bit          m_pos_ok;

    // Per-request outcome flags.
    bit         f_rep, f_stop, f_save;
    logic [2:0] f_state;
    logic [1:0] f_retry;

    t_res       door_reports_q[$];
    int         fails;
    bit         no_gap;
    bit         rx_hold;
    bit         row_typed;
    t_res       row_res;
    int         enc_ix;

    function automatic int sx(logic [15:0] v);
        return int'($signed(v));
    endfunction

    function automatic int absv(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void post_report(logic [2:0] st);
        f_rep = 1'b1;
        f_state = st;
        if (st == ST_CLOSED) begin
            m_pos = 0;
            m_pos_ok = 1'b1;
        end else if (st == ST_OPEN) begin
            m_pos = 100;
            m_pos_ok = 1'b1;
        end
    endfunction

    // Apply a new step count: direction tracking, position and motion report.
    function automatic void apply_steps(logic [15:0] raw_u);
        int raw, delta, lo, hi, dc, dop, n, d, pct;
        logic [1:0]  eff;
        logic [2:0]  motion;
        logic [15:0] diff;
        bit          correct;
        raw = sx(raw_u);
        diff = raw_u - m_applied;
        delta = sx(diff);
        m_applied = raw_u;
        if (delta == 0) return;
        m_last = delta > 0 ? DIR_UP : DIR_DOWN;
        if (m_travel == DIR_IDLE) begin
            m_travel = m_last;
            m_revcnt = '0;
        end else if (m_last != m_travel) begin
            m_revcnt = m_revcnt + 4'd1;
            if (int'(m_revcnt) >= c_thr) begin
                m_travel = m_last;
                m_revcnt = '0;
            end
        end else begin
            m_revcnt = '0;
        end

        if (m_lo_ok && m_hi_ok && m_lo != m_hi) begin
            lo = sx(m_lo);
            hi = sx(m_hi);
            dc = absv(raw - lo);
            dop = absv(raw - hi);
            if (dc <= 1 && dc <= dop) begin
                pct = c_rev ? 100 : 0;
            end else if (dop <= 1 && dop < dc) begin
                pct = c_rev ? 0 : 100;
            end else begin
                n = raw - lo;
                d = hi - lo;
                if (d < 0) begin
                    n = -n;
                    d = -d;
                end
                if (c_rev) n = d - n;
                if (n <= 0) pct = 0;
                else if (n >= d) pct = 100;
                else pct = (200 * n + d) / (2 * d);
            end
            m_pos = pct;
            m_pos_ok = 1'b1;

            eff = m_travel != DIR_IDLE ? m_travel : m_last;
            if (eff == DIR_UP) motion = c_rev ? ST_CLOSING : ST_OPENING;
            else motion = c_rev ? ST_OPENING : ST_CLOSING;
            if (m_intent != INT_NONE) begin
                correct = (motion == ST_OPENING) == (m_intent == INT_OPEN);
                if (!correct) begin
                    m_corr = 1'b1;
                    m_corr_dir = m_intent;
                    m_intent = INT_NONE;
                    if (c_delay == 0) begin
                        f_stop = 1'b1;
                        m_countdown = 0;
                    end else begin
                        m_countdown = c_delay;
                    end
                end else begin
                    post_report(motion);
                end
            end else begin
                post_report(motion);
            end
        end
        m_ms_step = 0;
        m_wd = 1'b1;
    endfunction

    function automatic void mark_end(bit dec);
        if (dec) m_lo = m_applied;
        else m_hi = m_applied;
        f_save = 1'b1;
    endfunction

    // Door declared stopped: retry a correction, or learn/snap/extend a limit.
    function automatic void door_halted();
        bit dec, ac, ao, beyond;
        int cur, lo, hi, t_cl, t_op, dc, dop;
        if (m_corr) begin
            m_corr = 1'b0;
            if (m_corr_dir == INT_OPEN) f_retry = RETRY_OPEN;
            else if (m_corr_dir == INT_CLOSE) f_retry = RETRY_CLOSE;
            m_corr_dir = INT_NONE;
            return;
        end
        dec = m_travel == DIR_DOWN;
        m_travel = DIR_IDLE;
        m_revcnt = '0;
        m_intent = INT_NONE;
        if (!(m_lo_ok && m_hi_ok)) begin
            mark_end(dec);
            if (dec) m_lo_ok = 1'b1;
            else m_hi_ok = 1'b1;
            if (dec) post_report(c_rev ? ST_OPEN : ST_CLOSED);
            else post_report(c_rev ? ST_CLOSED : ST_OPEN);
            return;
        end
        cur = sx(m_applied);
        lo = sx(m_lo);
        hi = sx(m_hi);
        t_cl = c_rev ? hi : lo;
        t_op = c_rev ? lo : hi;
        dc = absv(cur - t_cl);
        dop = absv(cur - t_op);
        ac = dec == !c_rev;
        ao = dec == (c_rev != 0);
        beyond = dec ? (cur < lo) : (cur > hi);
        if (dc <= 1 && dc <= dop && ac) begin
            mark_end(dec);
            post_report(ST_CLOSED);
        end else if (dop <= 1 && dop < dc && ao) begin
            mark_end(dec);
            post_report(ST_OPEN);
        end else if (ao && beyond) begin
            mark_end(dec);
            post_report(ST_OPEN);
        end else if (ac && beyond) begin
            mark_end(dec);
            post_report(ST_CLOSED);
        end else begin
            post_report(ST_STOPPED);
        end
    endfunction

    // One millisecond: stop countdown, then drain, then watchdog.
    function automatic void ms_tick();
        logic [15:0] d;
        if (m_countdown != 0) begin
            m_countdown--;
            if (m_countdown == 0) f_stop = 1'b1;
        end
        if (m_ms_step < 65535) m_ms_step++;
        if (m_ms_drain < 65535) m_ms_drain++;
        if (m_ms_drain >= c_drain) begin
            d = m_pend;
            m_ms_drain = 0;
            m_pend = '0;
            if (d != 0) apply_steps(m_applied + d);
        end
        if (m_wd && m_ms_step >= c_timeout) begin
            m_wd = 1'b0;
            door_halted();
        end
    endfunction

    function automatic t_res door_predict(t_req r);
        t_res       res;
        logic [1:0] pins;
        int         s;
        pins = {r.pin_a, r.pin_b};
        f_rep = 1'b0;
        f_stop = 1'b0;
        f_save = 1'b0;
        f_state = ST_OPEN;
        f_retry = RETRY_NONE;
        case (r.func)
            FN_SAMPLE: begin
                s = quad_lut[{m_pins, pins}];
                m_pins = pins;
                if (s != 0) begin
                    m_sub += s;
                    if (m_sub >= c_sub) begin
                        m_pend = m_pend + 16'd1;
                        m_sub = 0;
                    end else if (m_sub <= -c_sub) begin
                        m_pend = m_pend - 16'd1;
                        m_sub = 0;
                    end
                end
            end
            FN_TICK:  ms_tick();
            FN_OPEN:  m_intent = INT_OPEN;
            FN_CLOSE: m_intent = INT_CLOSE;
            FN_CLEAR: begin
                m_pend = '0;
                m_sub = 0;
                m_applied = '0;
                m_lo = '0;
                m_hi = '0;
                m_lo_ok = 1'b0;
                m_hi_ok = 1'b0;
                m_travel = DIR_IDLE;
                m_revcnt = '0;
                m_intent = INT_NONE;
                m_corr = 1'b0;
                m_wd = 1'b0;
                f_save = 1'b1;
            end
            FN_PRIME: begin
                m_pins = pins;
                m_pend = '0;
            end
            default: ;
        endcase
        res.report_valid   = f_rep;
        res.door_status    = f_rep ? f_state : ST_OPEN;
        res.position_known = m_pos_ok;
        res.position_pct   = m_pos_ok ? 7'(m_pos) : 7'd0;
        res.step_count     = m_applied;
        res.stop_request   = f_stop;
        res.retry_command  = f_retry;
        res.save_request   = f_save;
        res.low_limit      = m_lo;
        res.high_limit     = m_hi;
        return res;
    endfunction

    // Predict every accepted request; hand-written rows override the prediction.
    always @(posedge i_clk) begin
        t_res p;
        if (i_rst_n && push && !full) begin
            p = door_predict(i_req);
            door_reports_q.push_back(row_typed ? row_res : p);
        end
    end

    task automatic cmp_field(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
            fails++;
        end
    endtask

    // Compare each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && pop && !empty) begin
            if (door_reports_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                fails++;
            end else begin
                e = door_reports_q.pop_front();
                cmp_field("report_valid", e.report_valid, o_res.report_valid);
                cmp_field("door_status", e.door_status, o_res.door_status);
                cmp_field("position_known", e.position_known, o_res.position_known);
                cmp_field("position_pct", e.position_pct, o_res.position_pct);
                cmp_field("step_count", e.step_count, o_res.step_count);
                cmp_field("stop_request", e.stop_request, o_res.stop_request);
                cmp_field("retry_command", e.retry_command, o_res.retry_command);
                cmp_field("save_request", e.save_request, o_res.save_request);
                cmp_field("low_limit", e.low_limit, o_res.low_limit);
                cmp_field("high_limit", e.high_limit, o_res.high_limit);
            end
        end
    end

    // Result side: random stall per result, one long hold-off on request.
    initial begin
        int gap;
        int held;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                held = 0;
                while (held < 300) begin
                    @(negedge i_clk);
                    pop <= 1'b0;
                    held++;
                end
            end
            gap = no_gap ? 0 : $urandom_range(0, 15);
            repeat (gap) begin
                @(negedge i_clk);
                pop <= 1'b0;
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (!(pop && !empty));
        end
    end

    // Offer one request after a random gap and hold it until taken.
    task automatic send_req(t_req r, bit typed, t_res ex);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_req <= r;
        row_typed <= typed;
        row_res <= ex;
        do @(posedge i_clk); while (!(push && !full));
        if ($urandom_range(0, 49) == 0) no_gap = !no_gap;
    endtask

    task automatic send_plain(logic [2:0] fn, logic a, logic b);
        t_req r;
        r.func = fn;
        r.pin_a = a;
        r.pin_b = b;
        send_req(r, 1'b0, '0);
        if (fn == FN_SAMPLE || fn == FN_PRIME) begin
            for (int k = 0; k < 4; k++)
                if (gray_seq[k] == {a, b}) enc_ix = k;
        end
    endtask

    // Wait until every request has its result, then let the back end settle.
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (door_reports_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic wr_reg(logic [2:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int rev, int drain, int tmo, int thr, int dly, int sub);
        wr_reg(CFG_REVERSED, rev);
        wr_reg(CFG_DRAIN, drain);
        wr_reg(CFG_TIMEOUT, tmo);
        wr_reg(CFG_REV_THR, thr);
        wr_reg(CFG_STOP_DLY, dly);
        wr_reg(CFG_SUB_STEPS, sub);
        c_rev = rev & 1;
        c_drain = drain & 16'h3FF;
        c_timeout = tmo & 16'hFFFF;
        c_thr = thr & 4'hF;
        c_delay = dly & 16'hFFFF;
        c_sub = sub & 4'hF;
    endtask

    // Random traffic: mostly encoder motion with ticks, then pauses, intents, clears, primes and noise.
    task automatic random_phase(int target);
        int sent, kind, len, dir, ticks;
        logic [1:0] p;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                len = $urandom_range(4, 40);
                dir = $urandom_range(0, 1);
                for (int k = 0; k < len; k++) begin
                    // skip a state now and then
                    if ($urandom_range(0, 9) == 0) enc_ix = (enc_ix + 2) % 4;
                    else enc_ix = dir ? (enc_ix + 1) % 4 : (enc_ix + 3) % 4;
                    p = gray_seq[enc_ix];
                    send_plain(FN_SAMPLE, p[1], p[0]);
                    sent++;
                    if ($urandom_range(0, 2) == 0) begin
                        send_plain(FN_TICK, 1'b0, 1'b0);
                        sent++;
                    end
                end
            end else if (kind < 75) begin
                ticks = $urandom_range(1, 30);
                repeat (ticks) send_plain(FN_TICK, 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)));
                sent += ticks;
            end else if (kind < 84) begin
                send_plain($urandom_range(0, 1) ? FN_OPEN : FN_CLOSE,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else if (kind < 86) begin
                send_plain(FN_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else if (kind < 91) begin
                send_plain(FN_PRIME, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_plain(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial begin
        t_dir_row   dir_rows[$];
        t_res       zr, zs;
        t_req       rq;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_REVERSED;
        i_cfg_data = '0;
        row_typed = 1'b0;
        row_res = '0;
        no_gap = 1'b0;
        rx_hold = 1'b0;
        fails = 0;
        enc_ix = 0;
        c_rev = 0;
        c_drain = DRAIN_RST;
        c_timeout = TIMEOUT_RST;
        c_thr = REV_THR_RST;
        c_delay = STOP_DLY_RST;
        c_sub = SUB_STEPS_RST;
        m_pins = '0;
        m_sub = 0;
        m_pend = '0;
        m_applied = '0;
        m_lo = '0;
        m_hi = '0;
        m_lo_ok = 1'b0;
        m_hi_ok = 1'b0;
        m_travel = DIR_IDLE;
        m_last = DIR_IDLE;
        m_intent = INT_NONE;
        m_corr_dir = INT_NONE;
        m_revcnt = '0;
        m_corr = 1'b0;
        m_wd = 1'b0;
        m_ms_step = 0;
        m_ms_drain = 0;
        m_countdown = 0;
        m_pos = 0;
        m_pos_ok = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows at reset settings; hand-written results are all zero but the clear's save request.
        zr = '0;
        zs = '0;
        zs.save_request = 1'b1;
        dir_rows.push_back('{'{FN_TICK, 1'b0, 1'b0}, 1'b1, zr});
        dir_rows.push_back('{'{FN_CLEAR, 1'b1, 1'b1}, 1'b1, zs});
        dir_rows.push_back('{'{FN_PRIME, 1'b1, 1'b1}, 1'b1, zr});
        dir_rows.push_back('{'{3'd6, 1'b0, 1'b1}, 1'b1, zr});
        dir_rows.push_back('{'{3'd7, 1'b1, 1'b0}, 1'b1, zr});
        dir_rows.push_back('{'{FN_OPEN, 1'b0, 1'b0}, 1'b1, zr});
        dir_rows.push_back('{'{FN_CLOSE, 1'b1, 1'b1}, 1'b1, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b1, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b0, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b0, 1'b1}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b1, 1'b1}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b0, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b0, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b0, 1'b1}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b0, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_SAMPLE, 1'b1, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_TICK, 1'b1, 1'b1}, 1'b0, zr});
        dir_rows.push_back('{'{FN_PRIME, 1'b0, 1'b0}, 1'b0, zr});
        dir_rows.push_back('{'{FN_TICK, 1'b0, 1'b0}, 1'b0, zr});
        foreach (dir_rows[k]) begin
            rq = dir_rows[k].req;
            send_req(rq, dir_rows[k].typed, dir_rows[k].res);
        end
        drain_results();

        // Random phases, each at its own register setting.
        set_regs(0, 1, 4, 1, 0, 1);
        random_phase(110);
        drain_results();

        set_regs(1, 2, 8, 3, 3, 4);
        rx_hold = 1'b1;
        random_phase(110);
        drain_results();

        set_regs(0, 0, 0, 0, 0, 0);
        random_phase(110);
        drain_results();

        set_regs(1, 1000, 65535, 15, 65535, 15);
        random_phase(30);
        drain_results();

        set_regs(0, 3, 12, 2, 5, 2);
        random_phase(110);
        drain_results();

        set_regs(1, 1, 6, 15, 1, 15);
        random_phase(110);
        drain_results();

        set_regs(0, 5, 20, 4, 2, 4);
        random_phase(110);
        drain_results();

        set_regs(1, 1, 3, 1, 0, 1);
        random_phase(110);
        drain_results();

        if (fails == 0)
            $display("encoder_door_position_tracker test passed");
        else
            $display("encoder_door_position_tracker test failed");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #20_000_000;
        $display("encoder_door_position_tracker test failed");
        $finish;
    end

endmodule

[encoder_door_position_tracker.f]
sv/edpt_pkg.sv
sv/edpt_front.sv
sv/edpt_queue.sv
sv/edpt_back.sv
sv/encoder_door_position_tracker.sv
sim/tb_encoder_door_position_tracker.sv
